>>> rtl/mi3_pkg.sv
// Shared constants and types for the 3x3 matrix inverse.
`timescale 1ns / 1ps

package mi3_pkg;

    localparam int unsigned NUM_ENTRIES = 9;
    localparam int unsigned NUM_COLS    = 3;

    // Entry indexes (column * 3 + row) of the two products of each cofactor.
    localparam int unsigned COF_IDX [NUM_ENTRIES][4] = '{
        '{4, 8, 5, 7},
        '{7, 2, 1, 8},
        '{1, 5, 2, 4},
        '{6, 5, 3, 8},
        '{0, 8, 6, 2},
        '{2, 3, 0, 5},
        '{3, 7, 6, 4},
        '{1, 6, 0, 7},
        '{0, 4, 1, 3}
    };

    typedef struct packed {
        logic saturated;
        logic singular;
    } t_flags;

endpackage

>>> rtl/matrix_inverse_3x3.sv
// Top level of the pipelined 3x3 matrix inverse.
//
// Inverts one 3x3 fixed-point matrix per word by the adjugate method. Entries
// arrive column-major in s_axis_tdata and leave in the same order in
// m_axis_tdata, saturated to the entry range; m_axis_tuser carries the
// singular and saturated flags. The block takes one word every cycle while
// the output side keeps up; a stall on m_axis_tready freezes the whole
// pipeline. Words pass through the cofactor and determinant stages, a stage
// per quotient bit in the nine parallel restoring divider lanes, and the
// output register.
`timescale 1ns / 1ps

module matrix_inverse_3x3 #(
    parameter int unsigned ENTRY_WIDTH = 32,
    parameter int unsigned FRAC_BITS   = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        s_axis_tvalid,
    output logic                                        s_axis_tready,
    // m_c0_r0, m_c0_r1, m_c0_r2, m_c1_r0 .. m_c2_r2, zero padded
    input  logic [((9*ENTRY_WIDTH+7)/8)*8-1:0]          s_axis_tdata,
    output logic                                        m_axis_tvalid,
    input  logic                                        m_axis_tready,
    // inv_c0_r0, inv_c0_r1, inv_c0_r2, inv_c1_r0 .. inv_c2_r2, zero padded
    output logic [((9*ENTRY_WIDTH+7)/8)*8-1:0]          m_axis_tdata,
    // singular, saturated
    output logic [1:0]                                  m_axis_tuser
);

    localparam int unsigned W   = ENTRY_WIDTH;
    localparam int unsigned N   = mi3_pkg::NUM_ENTRIES;
    localparam int unsigned NB  = 2 * ENTRY_WIDTH + 2 * FRAC_BITS + 1;
    localparam int unsigned DB  = 3 * ENTRY_WIDTH + 3;
    localparam int unsigned LAT = NB + 6;
    localparam int unsigned TDW = ((9 * ENTRY_WIDTH + 7) / 8) * 8;

    logic                 w_en;
    logic [LAT-1:0]       r_vld;
    logic signed [W-1:0]  w_ent  [N];
    logic [2*W:0]         w_kmag [N];
    logic                 w_kneg [N];
    logic [DB-1:0]        w_dmag;
    logic                 w_dneg;
    logic                 w_dzero;
    logic [NB-1:0][DB-1:0] w_den;
    logic [DB-1:0]        r_den  [NB-1];
    logic                 r_zero [NB];
    logic                 w_zero [NB+1];
    logic [NB-1:0]        w_quo  [N];
    logic                 w_qneg [N];
    logic [W-1:0]         w_inv  [N];
    mi3_pkg::t_flags      w_flags;

    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++) begin : g_io
            assign w_ent[gi] = s_axis_tdata[gi*W +: W];
            assign m_axis_tdata[gi*W +: W] = w_inv[gi];
        end
        if (TDW > 9 * W) begin : g_pad
            assign m_axis_tdata[TDW-1:9*W] = '0;
        end
    endgenerate

    assign m_axis_tuser = {w_flags.saturated, w_flags.singular};

    mi3_front #(
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_ent   (w_ent),
        .o_kmag  (w_kmag),
        .o_kneg  (w_kneg),
        .o_dmag  (w_dmag),
        .o_dneg  (w_dneg),
        .o_dzero (w_dzero)
    );

    // Divisor and singular flag travel beside the divider stages.
    assign w_zero[0] = w_dzero ^ (w_dneg & 1'b0);
    generate
        for (gi = 0; gi < NB; gi++) begin : g_den
            if (gi == 0) begin : g_head
                assign w_den[gi] = w_dmag;
            end else begin : g_tail
                assign w_den[gi] = r_den[gi-1];
            end
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_zero[gi] <= w_zero[gi];
                end
            end
            if (gi < NB - 1) begin : g_pass
                always_ff @(posedge i_clk) begin
                    if (w_en) begin
                        r_den[gi] <= w_den[gi];
                    end
                end
            end
            assign w_zero[gi+1] = r_zero[gi];
        end

        for (gi = 0; gi < N; gi++) begin : g_lane
            mi3_div_lane #(
                .ENTRY_WIDTH (ENTRY_WIDTH),
                .FRAC_BITS   (FRAC_BITS)
            ) u_lane (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_num (w_kmag[gi]),
                .i_neg (w_kneg[gi] ^ w_dneg),
                .i_den (w_den),
                .o_quo (w_quo[gi]),
                .o_neg (w_qneg[gi])
            );
        end
    endgenerate

    mi3_merge #(
        .ENTRY_WIDTH (ENTRY_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_merge (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_quo   (w_quo),
        .i_neg   (w_qneg),
        .i_zero  (w_zero[NB]),
        .o_inv   (w_inv),
        .o_flags (w_flags)
    );

endmodule

>>> rtl/mi3_front.sv
// Cofactor and determinant pipeline, five stages, with sign and magnitude split.
`timescale 1ns / 1ps

module mi3_front #(
    parameter int unsigned ENTRY_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [ENTRY_WIDTH-1:0]     i_ent [mi3_pkg::NUM_ENTRIES],
    output logic [2*ENTRY_WIDTH:0]            o_kmag [mi3_pkg::NUM_ENTRIES],
    output logic                              o_kneg [mi3_pkg::NUM_ENTRIES],
    output logic [3*ENTRY_WIDTH+2:0]          o_dmag,
    output logic                              o_dneg,
    output logic                              o_dzero
);

    localparam int unsigned W  = ENTRY_WIDTH;
    localparam int unsigned N  = mi3_pkg::NUM_ENTRIES;
    localparam int unsigned NC = mi3_pkg::NUM_COLS;
    localparam int unsigned DW = 3 * ENTRY_WIDTH + 3;

    logic signed [2*W-1:0] r_pa [N];
    logic signed [2*W-1:0] r_pb [N];
    logic signed [2*W:0]   r_k  [N];
    logic signed [2*W:0]   r_k3 [N];
    logic signed [2*W:0]   r_k4 [N];
    logic signed [W-1:0]   r_a1 [NC];
    logic signed [W-1:0]   r_a2 [NC];
    logic signed [2*W:0]   r_dl [NC];
    logic signed [2*W:0]   r_dh [NC];
    logic signed [DW-1:0]  r_det;
    logic signed [DW-1:0]  n_det;

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++) begin : g_cof
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_pa[gi] <= i_ent[mi3_pkg::COF_IDX[gi][0]] * i_ent[mi3_pkg::COF_IDX[gi][1]];
                    r_pb[gi] <= i_ent[mi3_pkg::COF_IDX[gi][2]] * i_ent[mi3_pkg::COF_IDX[gi][3]];
                    r_k[gi]  <= {r_pa[gi][2*W-1], r_pa[gi]} - {r_pb[gi][2*W-1], r_pb[gi]};
                    r_k3[gi] <= r_k[gi];
                    r_k4[gi] <= r_k3[gi];
                    o_kneg[gi] <= r_k4[gi][2*W];
                    o_kmag[gi] <= r_k4[gi][2*W] ? -r_k4[gi] : r_k4[gi];
                end
            end
        end
        for (gi = 0; gi < NC; gi++) begin : g_det
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_a1[gi] <= i_ent[3*gi];
                    r_a2[gi] <= r_a1[gi];
                    r_dl[gi] <= r_a2[gi] * $signed({1'b0, r_k[gi][W-1:0]});
                    r_dh[gi] <= r_a2[gi] * $signed(r_k[gi][2*W:W]);
                end
            end
        end
    endgenerate

    always_comb begin
        n_det = '0;
        for (int j = 0; j < NC; j++) begin
            n_det = n_det + (DW'(r_dh[j]) <<< W) + DW'(r_dl[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_det   <= n_det;
            o_dneg  <= r_det[DW-1];
            o_dmag  <= r_det[DW-1] ? -r_det : r_det;
            o_dzero <= (r_det == '0);
        end
    end

endmodule

>>> rtl/mi3_div_lane.sv
// One lane of the pipelined restoring divider: one quotient bit per stage.
`timescale 1ns / 1ps

module mi3_div_lane #(
    parameter int unsigned ENTRY_WIDTH = 32,
    parameter int unsigned FRAC_BITS   = 16
) (
    input  logic                                               i_clk,
    input  logic                                               i_en,
    input  logic [2*ENTRY_WIDTH:0]                             i_num,
    input  logic                                               i_neg,
    input  logic [2*ENTRY_WIDTH+2*FRAC_BITS:0][3*ENTRY_WIDTH+2:0] i_den,
    output logic [2*ENTRY_WIDTH+2*FRAC_BITS:0]                 o_quo,
    output logic                                               o_neg
);

    localparam int unsigned NB = 2 * ENTRY_WIDTH + 2 * FRAC_BITS + 1;
    localparam int unsigned DB = 3 * ENTRY_WIDTH + 3;

    logic [DB-1:0] r_rem [NB-1];
    logic [NB-1:0] r_num [NB-1];
    logic [NB-1:0] r_quo [NB];
    logic          r_neg [NB];

    genvar s;
    generate
        for (s = 0; s < NB; s++) begin : g_stage
            logic [DB-1:0] w_rem;
            logic [NB-1:0] w_num;
            logic [NB-1:0] w_quo;
            logic          w_neg;
            logic [DB:0]   w_trial;
            logic          w_ge;
            logic [DB-1:0] n_rem;

            if (s == 0) begin : g_first
                assign w_rem = '0;
                assign w_num = NB'(i_num) << (2 * FRAC_BITS);
                assign w_quo = '0;
                assign w_neg = i_neg;
            end else begin : g_next
                assign w_rem = r_rem[s-1];
                assign w_num = r_num[s-1];
                assign w_quo = r_quo[s-1];
                assign w_neg = r_neg[s-1];
            end

            assign w_trial = {w_rem, w_num[NB-1]};
            assign w_ge    = (w_trial >= {1'b0, i_den[s]});
            assign n_rem   = w_ge ? DB'(w_trial - {1'b0, i_den[s]}) : w_trial[DB-1:0];

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_quo[s] <= {w_quo[NB-2:0], w_ge};
                    r_neg[s] <= w_neg;
                end
            end

            if (s < NB - 1) begin : g_carry
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_rem[s] <= n_rem;
                        r_num[s] <= w_num << 1;
                    end
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[NB-1];
    assign o_neg = r_neg[NB-1];

endmodule

>>> rtl/mi3_merge.sv
// Output stage: sign, saturation and singular handling across all lanes.
`timescale 1ns / 1ps

module mi3_merge #(
    parameter int unsigned ENTRY_WIDTH = 32,
    parameter int unsigned FRAC_BITS   = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic [2*ENTRY_WIDTH+2*FRAC_BITS:0]     i_quo [mi3_pkg::NUM_ENTRIES],
    input  logic                                   i_neg [mi3_pkg::NUM_ENTRIES],
    input  logic                                   i_zero,
    output logic [ENTRY_WIDTH-1:0]                 o_inv [mi3_pkg::NUM_ENTRIES],
    output mi3_pkg::t_flags                        o_flags
);

    localparam int unsigned W  = ENTRY_WIDTH;
    localparam int unsigned NB = 2 * ENTRY_WIDTH + 2 * FRAC_BITS + 1;
    localparam int unsigned N  = mi3_pkg::NUM_ENTRIES;
    localparam logic [NB-1:0] HALF = NB'(1) << (W - 1);

    logic [W-1:0]    n_inv [N];
    logic [N-1:0]    n_clip;
    mi3_pkg::t_flags n_flags;

    always_comb begin
        logic [NB-1:0] lim;
        logic [W-1:0]  mag;
        for (int i = 0; i < N; i++) begin
            lim       = i_neg[i] ? HALF : HALF - NB'(1);
            n_clip[i] = (i_quo[i] > lim);
            mag       = n_clip[i] ? lim[W-1:0] : i_quo[i][W-1:0];
            n_inv[i]  = i_zero ? '0 : (i_neg[i] ? -mag : mag);
        end
        n_flags.singular  = i_zero;
        n_flags.saturated = !i_zero && (|n_clip);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_inv   <= n_inv;
            o_flags <= n_flags;
        end
    end

endmodule

>>> tb/matrix_inverse_3x3_tb.sv
// Testbench for matrix_inverse_3x3: streams matrices and checks every inverse word.
`timescale 1ns / 1ps

module matrix_inverse_3x3_tb;

    localparam int EW = 32;
    localparam int FB = 16;
    localparam int DW = 9 * EW;
    localparam int PIPE_LATENCY = 2 * EW + 2 * FB + 7;
    localparam int CYCLE_LIMIT = 400000;

    typedef logic signed [255:0] t_wide;

    typedef struct packed {
        logic [DW-1:0] inv;
        logic          saturated;
        logic          singular;
    } t_inverse;

    logic          i_clk;
    logic          i_rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [DW-1:0] s_axis_tdata;   // m_c0_r0, m_c0_r1 .. m_c2_r2
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [DW-1:0] m_axis_tdata;   // inv_c0_r0, inv_c0_r1 .. inv_c2_r2
    logic [1:0]    m_axis_tuser;   // singular, saturated

    t_inverse inverse_queue[$];
    int       error_count;
    int       cycle_count;
    int       sent_count;
    int       checked_count;
    int       singular_count;
    int       saturated_count;
    bit       sender_idle_en;
    bit       receiver_idle_en;
    int       hold_request;

    matrix_inverse_3x3 uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_wide cross_term(t_wide a, t_wide b, t_wide c, t_wide d);
        return a * b - c * d;
    endfunction

    function automatic t_inverse invert_matrix(logic [DW-1:0] m);
        t_wide         a[9];
        t_wide         k[9];
        t_wide         det;
        logic [255:0]  num;
        logic [255:0]  den;
        logic [255:0]  quo;
        logic [255:0]  lim;
        logic [EW-1:0] word;
        bit            neg;
        t_inverse      r;
        for (int i = 0; i < 9; i++) begin
            a[i] = {{(256-EW){m[i*EW+EW-1]}}, m[i*EW +: EW]};
        end
        k[0] = cross_term(a[4], a[8], a[5], a[7]);
        k[1] = cross_term(a[7], a[2], a[1], a[8]);
        k[2] = cross_term(a[1], a[5], a[2], a[4]);
        k[3] = cross_term(a[6], a[5], a[3], a[8]);
        k[4] = cross_term(a[0], a[8], a[6], a[2]);
        k[5] = cross_term(a[2], a[3], a[0], a[5]);
        k[6] = cross_term(a[3], a[7], a[6], a[4]);
        k[7] = cross_term(a[1], a[6], a[0], a[7]);
        k[8] = cross_term(a[0], a[4], a[1], a[3]);
        det = a[0] * k[0] + a[3] * k[1] + a[6] * k[2];
        r = '0;
        if (det == 0) begin
            r.singular = 1'b1;
            return r;
        end
        den = (det < 0) ? -det : det;
        for (int i = 0; i < 9; i++) begin
            neg = (k[i] < 0) != (det < 0);
            num = ((k[i] < 0) ? -k[i] : k[i]);
            num = num << (2 * FB);
            quo = num / den;
            lim = neg ? (256'd1 << (EW - 1)) : ((256'd1 << (EW - 1)) - 1);
            if (quo > lim) begin
                quo = lim;
                r.saturated = 1'b1;
            end
            word = neg ? -quo[EW-1:0] : quo[EW-1:0];
            r.inv[i*EW +: EW] = word;
        end
        return r;
    endfunction

    // Driver: called at a falling edge, returns at a falling edge with valid still high.
    task automatic send_matrix(input logic [DW-1:0] m);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = m;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        inverse_queue.push_back(invert_matrix(m));
        sent_count++;
        @(negedge i_clk);
    endtask

    task automatic sender_gap();
        int n;
        if (sender_idle_en && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 19);
            s_axis_tvalid = 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    function automatic logic [EW-1:0] q16(int v);
        return EW'(v) << FB;
    endfunction

    function automatic logic [DW-1:0] pack9(logic [EW-1:0] e0, logic [EW-1:0] e1,
                                            logic [EW-1:0] e2, logic [EW-1:0] e3,
                                            logic [EW-1:0] e4, logic [EW-1:0] e5,
                                            logic [EW-1:0] e6, logic [EW-1:0] e7,
                                            logic [EW-1:0] e8);
        return {e8, e7, e6, e5, e4, e3, e2, e1, e0};
    endfunction

    function automatic logic [EW-1:0] random_entry(int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            2: return $urandom_range(0, 32'h0000_2000) - 32'h0000_1000;
            default: return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
        endcase
    endfunction

    function automatic logic [DW-1:0] random_matrix();
        logic [DW-1:0] m;
        int            mode;
        int            src;
        int            dst;
        mode = $urandom_range(0, 3);
        for (int i = 0; i < 9; i++) m[i*EW +: EW] = random_entry(mode);
        case ($urandom_range(0, 9))
            0: begin
                // duplicate a column to make it singular
                src = $urandom_range(0, 2);
                dst = (src + $urandom_range(1, 2)) % 3;
                m[dst*3*EW +: 3*EW] = m[src*3*EW +: 3*EW];
            end
            1: begin
                for (int i = 0; i < 9; i += 4) m[i*EW +: EW] += q16(4);
            end
            2: m[$urandom_range(0, 8)*EW +: EW] = $urandom_range(0, 1) ? 32'h8000_0000
                                                                     : 32'h7fff_ffff;
            default: ;
        endcase
        return m;
    endfunction

    task automatic test_directed();
        send_matrix(pack9(q16(1), 0, 0, 0, q16(1), 0, 0, 0, q16(1)));
        send_matrix('0);
        send_matrix(pack9(q16(2), 0, 0, 0, q16(4), 0, 0, 0, -q16(8)));
        send_matrix(pack9(q16(1), q16(2), q16(3), q16(4), q16(5), q16(6),
                          q16(7), q16(8), q16(10)));
        send_matrix(pack9(q16(1), q16(2), q16(3), q16(2), q16(4), q16(6),
                          q16(0), q16(1), q16(1)));
        send_matrix(pack9(1, 0, 0, 0, 1, 0, 0, 0, 1));
        send_matrix(pack9(-1, 0, 0, 0, 1, 0, 0, 0, 1));
        send_matrix(pack9(32'h7fff_ffff, 0, 0, 0, 32'h7fff_ffff, 0, 0, 0, 32'h7fff_ffff));
        send_matrix(pack9(32'h8000_0000, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 32'h8000_0000));
        send_matrix({9{32'h8000_0000}});
        send_matrix({9{32'hffff_ffff}});
        send_matrix(pack9(32'h7fff_ffff, 32'h8000_0000, 1, 32'h8000_0000, 32'h7fff_ffff,
                          -1, 1, 32'h0001_0000, 32'h8000_0000));
        send_matrix(pack9(0, q16(1), 0, q16(1), 0, 0, 0, 0, q16(1)));
        send_matrix(pack9(0, 0, q16(3), 0, -q16(3), 0, q16(3), 0, 0));
        send_matrix(pack9(32'h0000_8000, 0, 0, 0, 32'h0000_4000, 0, 0, 0, 32'h0002_0000));
        send_matrix(pack9(q16(1), q16(1), 0, 0, q16(1), q16(1), q16(1), 0, q16(1)));
        send_matrix(pack9(32'h5555_5555, 32'haaaa_aaaa, 32'h1234_5678, 32'hedcb_a987,
                          32'h0f0f_0f0f, 32'hf0f0_f0f0, 32'h3333_3333, 32'hcccc_cccc,
                          32'h7654_3210));
        s_axis_tvalid = 1'b0;
    endtask

    task automatic test_random(int count);
        for (int n = 0; n < count; n++) begin
            send_matrix(random_matrix());
            sender_gap();
        end
        s_axis_tvalid = 1'b0;
    endtask

    task automatic test_backpressure();
        hold_request = 400;
        for (int n = 0; n < 150; n++) send_matrix(random_matrix());
        s_axis_tvalid = 1'b0;
    endtask

    task automatic test_streaming(int count);
        sender_idle_en   = 1'b0;
        receiver_idle_en = 1'b0;
        for (int n = 0; n < count; n++) send_matrix(random_matrix());
        s_axis_tvalid = 1'b0;
    endtask

    // Receiver: random stall bursts plus one long hold on request.
    initial begin
        int n;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                n = hold_request;
                hold_request = 0;
                m_axis_tready = 1'b0;
                repeat (n) @(negedge i_clk);
            end else if (receiver_idle_en && $urandom_range(0, 3) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 19) - 1) @(negedge i_clk);
            end else begin
                m_axis_tready = 1'b1;
                if (receiver_idle_en) repeat ($urandom_range(0, 20)) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_inverse want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (inverse_queue.size() == 0) begin
                $error("unexpected inverse word: data %h user %b", m_axis_tdata, m_axis_tuser);
                error_count++;
            end else begin
                want = inverse_queue.pop_front();
                checked_count++;
                singular_count  += want.singular;
                saturated_count += want.saturated;
                for (int i = 0; i < 9; i++) begin
                    if (m_axis_tdata[i*EW +: EW] !== want.inv[i*EW +: EW]) begin
                        $error("inv_c%0d_r%0d: expected %h, got %h", i / 3, i % 3,
                               want.inv[i*EW +: EW], m_axis_tdata[i*EW +: EW]);
                        error_count++;
                    end
                end
                if (m_axis_tuser[0] !== want.singular) begin
                    $error("singular: expected %b, got %b", want.singular, m_axis_tuser[0]);
                    error_count++;
                end
                if (m_axis_tuser[1] !== want.saturated) begin
                    $error("saturated: expected %b, got %b", want.saturated, m_axis_tuser[1]);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, inverse_queue.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int wait_cycles;
        error_count      = 0;
        cycle_count      = 0;
        sent_count       = 0;
        checked_count    = 0;
        singular_count   = 0;
        saturated_count  = 0;
        hold_request     = 0;
        sender_idle_en   = 1'b1;
        receiver_idle_en = 1'b1;
        s_axis_tvalid    = 1'b0;
        s_axis_tdata     = '0;
        i_rst_n          = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        test_random(1150);
        test_backpressure();
        test_streaming(330);

        wait_cycles = 0;
        while (inverse_queue.size() != 0 && wait_cycles < 50 * PIPE_LATENCY) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (PIPE_LATENCY + 20) @(posedge i_clk);
        if (inverse_queue.size() != 0) begin
            $error("%0d inverse words never arrived", inverse_queue.size());
            error_count++;
        end
        $display("sent %0d matrices, checked %0d inverses (%0d singular, %0d saturated)",
                 sent_count, checked_count, singular_count, saturated_count);
        $display("covered stall bursts on both sides, a long output hold and back-to-back flow");
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
